FILE: rtl/core/rvbb_pkg.sv
package rvbb_pkg;

    localparam int CENTER_BITS = 12;
    localparam int ANGLE_BITS  = 9;
    localparam int PLACE_BITS  = 14;
    localparam int ADDR_BITS   = 4;
    localparam int DATA_BITS   = 32;
    localparam int REG_LSB     = 2;
    localparam int QUARTER_DEG = 90;
    localparam int REM_BITS    = 7;

    localparam logic signed [PLACE_BITS-1:0] PLACE_MAX = 14'sd8191;
    localparam logic signed [PLACE_BITS-1:0] PLACE_MIN = -14'sd8192;

    localparam logic [ANGLE_BITS-1:0] DEG_90  = 9'd90;
    localparam logic [ANGLE_BITS-1:0] DEG_180 = 9'd180;
    localparam logic [ANGLE_BITS-1:0] DEG_270 = 9'd270;
    localparam logic [ANGLE_BITS-1:0] DEG_360 = 9'd360;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_CENTER_X = 2'd0;
    localparam logic [1:0] REG_CENTER_Y = 2'd1;
    localparam logic [1:0] REG_ROTATION = 2'd2;

    localparam longint unsigned PI_Q60     = 64'h3243F6A8885A308D;
    localparam longint unsigned PI_Q60_DEG = PI_Q60 / 180;

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_1,
        QUAD_2,
        QUAD_3
    } t_quad;

    typedef struct packed {
        logic [CENTER_BITS-1:0] center_x;
        logic [CENTER_BITS-1:0] center_y;
        logic [ANGLE_BITS-1:0]  rotation;
    } t_cfg;

    typedef struct packed {
        logic signed [PLACE_BITS-1:0] x;
        logic signed [PLACE_BITS-1:0] y;
        logic                         last;
    } t_point;

    // sin(d degrees) scaled by 2^frac, Taylor series in Q30, elaboration only
    function automatic longint unsigned sine_q(int unsigned d, int unsigned frac);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint          sum;
        int unsigned     shift;
        if (d == 0) begin
            return 64'd0;
        end
        if (d == QUARTER_DEG) begin
            return 64'd1 << frac;
        end
        x     = (PI_Q60_DEG * 64'(d) + (64'd1 << 29)) >> 30;
        x2    = (x * x) >> 30;
        t     = x;
        sum   = signed'(x);
        shift = 30 - frac;
        for (int unsigned n = 2; n <= 18; n += 2) begin
            t = ((t * x2) >> 30) / 64'(n * (n + 1));
            if (n[1]) begin
                sum -= signed'(t);
            end else begin
                sum += signed'(t);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > (64'sd1 <<< 30)) begin
            sum = 64'sd1 <<< 30;
        end
        return (unsigned'(sum) + (64'd1 << (shift - 1))) >> shift;
    endfunction

endpackage

FILE: rtl/core/rvbb_if.sv
interface rvbb_vertex_if #(
    parameter int VERTEX_BITS = 11
);
    logic                          valid;
    logic                          ready;
    logic signed [VERTEX_BITS-1:0] vertex_x;
    logic signed [VERTEX_BITS-1:0] vertex_y;
    logic                          last_vertex;

    modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
    modport sink   (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

interface rvbb_result_if;
    logic               valid;
    logic               ready;
    logic signed [13:0] placed_x;
    logic signed [13:0] placed_y;
    logic signed [13:0] box_left;
    logic signed [13:0] box_right;
    logic signed [13:0] box_top;
    logic signed [13:0] box_bottom;
    logic               box_final;

    modport source (output valid, placed_x, placed_y, box_left, box_right, box_top,
                    box_bottom, box_final, input ready);
    modport sink   (input valid, placed_x, placed_y, box_left, box_right, box_top,
                    box_bottom, box_final, output ready);
endinterface

FILE: rtl/core/rotate_vertices_bounding_box_core.sv
// Rotates polygon vertices about a configured center and tracks their bounding box.
// i_vertex: one vertex request per valid/ready handshake (offset x, y and last flag).
// o_result: one result request per vertex: placed x, y and the box so far; on the
// vertex flagged last, box_final is set and the box restarts for the next polygon.
// APB port: center_x at 0x0, center_y at 0x4, rotation in degrees at 0x8 (360 = 0).
// Sine and cosine are registered in the cycle after a rotation write; write while idle.
// Pipeline: input register, multiply stage, place/saturate stage, box/result register.
// A vertex passes the input, product, placed-point and result registers in turn.
// Throughput: one vertex per cycle while o_result is not stalled, set by the four pipeline registers.
// Each stage loads when empty or draining, so bubbles are absorbed while
// o_result is stalled; with all four stages full, i_vertex.ready drops.
// Reset (synchronous, active low): config registers to zero, cosine to one, pipeline empty, box cleared.
module rotate_vertices_bounding_box_core #(
    parameter int VERTEX_BITS    = 11,
    parameter int TRIG_FRAC_BITS = 14
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    rvbb_vertex_if.sink                    i_vertex,
    rvbb_result_if.source                  o_result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rvbb_pkg::ADDR_BITS-1:0] paddr,
    input  logic [rvbb_pkg::DATA_BITS-1:0] pwdata,
    output logic [rvbb_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready
);
    import rvbb_pkg::*;

    t_cfg                             cfg;
    logic signed [TRIG_FRAC_BITS+1:0] sin_val;
    logic signed [TRIG_FRAC_BITS+1:0] cos_val;
    t_point                           point;
    logic                             point_valid;
    logic                             point_ready;

    rvbb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rvbb_trig #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_trig (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rotation (cfg.rotation),
        .o_sin      (sin_val),
        .o_cos      (cos_val)
    );

    rvbb_datapath #(
        .VERTEX_BITS    (VERTEX_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_vertex      (i_vertex),
        .i_cfg         (cfg),
        .i_sin         (sin_val),
        .i_cos         (cos_val),
        .o_point       (point),
        .o_point_valid (point_valid),
        .i_point_ready (point_ready)
    );

    rvbb_box u_box (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_point       (point),
        .i_point_valid (point_valid),
        .o_point_ready (point_ready),
        .o_result      (o_result)
    );

endmodule

FILE: rtl/core/rvbb_regs.sv
module rvbb_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rvbb_pkg::ADDR_BITS-1:0] paddr,
    input  logic [rvbb_pkg::DATA_BITS-1:0] pwdata,
    output logic [rvbb_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready,
    output rvbb_pkg::t_cfg                 o_cfg
);
    import rvbb_pkg::*;

    t_cfg       r_cfg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_BITS-1:REG_LSB];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_CENTER_X: r_cfg.center_x <= pwdata[CENTER_BITS-1:0];
                REG_CENTER_Y: r_cfg.center_y <= pwdata[CENTER_BITS-1:0];
                REG_ROTATION: r_cfg.rotation <= pwdata[ANGLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_CENTER_X: prdata = DATA_BITS'(r_cfg.center_x);
            REG_CENTER_Y: prdata = DATA_BITS'(r_cfg.center_y);
            REG_ROTATION: prdata = DATA_BITS'(r_cfg.rotation);
            default:      prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/core/rvbb_trig.sv
module rvbb_trig #(
    parameter int TRIG_FRAC_BITS = 14
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [rvbb_pkg::ANGLE_BITS-1:0]   i_rotation,
    output logic signed [TRIG_FRAC_BITS+1:0]  o_sin,
    output logic signed [TRIG_FRAC_BITS+1:0]  o_cos
);
    import rvbb_pkg::*;

    localparam int TW = TRIG_FRAC_BITS + 2;
    localparam logic signed [TW-1:0] TRIG_ONE = TW'(2 ** TRIG_FRAC_BITS);

    logic [TRIG_FRAC_BITS:0]   rom [0:QUARTER_DEG];
    logic [ANGLE_BITS-1:0]     rot_norm;
    logic [ANGLE_BITS:0]       sum90;
    logic [ANGLE_BITS-1:0]     angle [2];
    logic signed [TW-1:0]      trig [2];
    logic signed [TW-1:0]      r_sin;
    logic signed [TW-1:0]      r_cos;

    for (genvar d = 0; d <= QUARTER_DEG; d++) begin : g_rom
        localparam longint unsigned ENTRY = sine_q(d, TRIG_FRAC_BITS);
        assign rom[d] = (TRIG_FRAC_BITS + 1)'(ENTRY);
    end

    always_comb begin
        rot_norm = (i_rotation >= DEG_360) ? i_rotation - DEG_360 : i_rotation;
        sum90    = {1'b0, rot_norm} + (ANGLE_BITS + 1)'(DEG_90);
        angle[0] = rot_norm;
        angle[1] = (sum90 >= (ANGLE_BITS + 1)'(DEG_360)) ?
                   ANGLE_BITS'(sum90 - (ANGLE_BITS + 1)'(DEG_360)) : sum90[ANGLE_BITS-1:0];
    end

    always_comb begin
        t_quad                   q;
        logic [REM_BITS-1:0]     rem;
        logic [TRIG_FRAC_BITS:0] mag;
        for (int k = 0; k < 2; k++) begin
            if (angle[k] >= DEG_270) begin
                q   = QUAD_3;
                rem = REM_BITS'(angle[k] - DEG_270);
            end else if (angle[k] >= DEG_180) begin
                q   = QUAD_2;
                rem = REM_BITS'(angle[k] - DEG_180);
            end else if (angle[k] >= DEG_90) begin
                q   = QUAD_1;
                rem = REM_BITS'(angle[k] - DEG_90);
            end else begin
                q   = QUAD_0;
                rem = REM_BITS'(angle[k]);
            end
            case (q)
                QUAD_0, QUAD_2: mag = rom[rem];
                QUAD_1, QUAD_3: mag = rom[REM_BITS'(DEG_90) - rem];
                default:        mag = '0;
            endcase
            trig[k] = (q inside {QUAD_2, QUAD_3}) ? -signed'({1'b0, mag})
                                                  : signed'({1'b0, mag});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sin <= '0;
            r_cos <= TRIG_ONE;
        end else begin
            r_sin <= trig[0];
            r_cos <= trig[1];
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

FILE: rtl/core/rvbb_datapath.sv
module rvbb_datapath #(
    parameter int VERTEX_BITS    = 11,
    parameter int TRIG_FRAC_BITS = 14
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    rvbb_vertex_if.sink                      i_vertex,
    input  rvbb_pkg::t_cfg                   i_cfg,
    input  logic signed [TRIG_FRAC_BITS+1:0] i_sin,
    input  logic signed [TRIG_FRAC_BITS+1:0] i_cos,
    output rvbb_pkg::t_point                 o_point,
    output logic                             o_point_valid,
    input  logic                             i_point_ready
);
    import rvbb_pkg::*;

    localparam int VB = VERTEX_BITS;
    localparam int TF = TRIG_FRAC_BITS;
    localparam int PW = VB + TF + 1;
    localparam int SW = PW + 1;
    localparam int RW = VB + 2;
    localparam int DW = ((CENTER_BITS + 1 > RW) ? CENTER_BITS + 1 : RW) + 1;
    localparam logic signed [SW-1:0] TRUNC_BIAS = SW'((2 ** TF) - 1);

    // stage 0: input register
    logic                 r_v0;
    logic signed [VB-1:0] r_vx0;
    logic signed [VB-1:0] r_vy0;
    logic                 r_last0;
    // stage 1: products
    logic                 r_v1;
    logic signed [PW-1:0] r_xc;
    logic signed [PW-1:0] r_ys;
    logic signed [PW-1:0] r_xs;
    logic signed [PW-1:0] r_yc;
    logic                 r_last1;
    // stage 2: placed point
    logic                 r_v2;
    t_point               r_pt;

    logic                 ld0;
    logic                 ld1;
    logic                 ld2;
    logic signed [PW-1:0] ext_vx;
    logic signed [PW-1:0] ext_vy;
    logic signed [PW-1:0] ext_sin;
    logic signed [PW-1:0] ext_cos;
    logic signed [PW-1:0] n_xc;
    logic signed [PW-1:0] n_ys;
    logic signed [PW-1:0] n_xs;
    logic signed [PW-1:0] n_yc;
    logic signed [SW-1:0] sum_x;
    logic signed [SW-1:0] sum_y;
    logic signed [SW-1:0] bias_x;
    logic signed [SW-1:0] bias_y;
    logic signed [RW-1:0] rx;
    logic signed [RW-1:0] ry;
    t_point               n_pt;

    function automatic logic signed [PLACE_BITS-1:0] place(
        logic [CENTER_BITS-1:0] center,
        logic signed [RW-1:0]   rot
    );
        logic signed [DW-1:0] diff;
        diff = DW'(signed'({1'b0, center})) - DW'(rot);
        if (diff > DW'(PLACE_MAX)) begin
            return PLACE_MAX;
        end
        if (diff < DW'(PLACE_MIN)) begin
            return PLACE_MIN;
        end
        return diff[PLACE_BITS-1:0];
    endfunction

    assign ld2 = !r_v2 || i_point_ready;
    assign ld1 = !r_v1 || ld2;
    assign ld0 = !r_v0 || ld1;
    assign i_vertex.ready = ld0;

    always_comb begin
        ext_vx  = PW'(r_vx0);
        ext_vy  = PW'(r_vy0);
        ext_sin = PW'(i_sin);
        ext_cos = PW'(i_cos);
        n_xc    = ext_vx * ext_cos;
        n_ys    = ext_vy * ext_sin;
        n_xs    = ext_vx * ext_sin;
        n_yc    = ext_vy * ext_cos;
    end

    // sum, truncate toward zero, subtract from center, saturate
    always_comb begin
        sum_x     = SW'(r_xc) - SW'(r_ys);
        sum_y     = SW'(r_xs) + SW'(r_yc);
        bias_x    = sum_x + (sum_x[SW-1] ? TRUNC_BIAS : '0);
        bias_y    = sum_y + (sum_y[SW-1] ? TRUNC_BIAS : '0);
        rx        = bias_x[SW-1:TF];
        ry        = bias_y[SW-1:TF];
        n_pt.x    = place(i_cfg.center_x, rx);
        n_pt.y    = place(i_cfg.center_y, ry);
        n_pt.last = r_last1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (ld0) begin
                r_v0 <= i_vertex.valid;
            end
            if (ld1) begin
                r_v1 <= r_v0;
            end
            if (ld2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld0) begin
            r_vx0   <= i_vertex.vertex_x;
            r_vy0   <= i_vertex.vertex_y;
            r_last0 <= i_vertex.last_vertex;
        end
        if (ld1) begin
            r_xc    <= n_xc;
            r_ys    <= n_ys;
            r_xs    <= n_xs;
            r_yc    <= n_yc;
            r_last1 <= r_last0;
        end
        if (ld2) begin
            r_pt <= n_pt;
        end
    end

    assign o_point       = r_pt;
    assign o_point_valid = r_v2;

endmodule

FILE: rtl/core/rvbb_box.sv
module rvbb_box (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rvbb_pkg::t_point i_point,
    input  logic             i_point_valid,
    output logic             o_point_ready,
    rvbb_result_if.source    o_result
);
    import rvbb_pkg::*;

    logic signed [PLACE_BITS-1:0] r_min_x;
    logic signed [PLACE_BITS-1:0] r_max_x;
    logic signed [PLACE_BITS-1:0] r_min_y;
    logic signed [PLACE_BITS-1:0] r_max_y;
    logic                         r_valid;
    logic signed [PLACE_BITS-1:0] r_px;
    logic signed [PLACE_BITS-1:0] r_py;
    logic signed [PLACE_BITS-1:0] r_left;
    logic signed [PLACE_BITS-1:0] r_right;
    logic signed [PLACE_BITS-1:0] r_top;
    logic signed [PLACE_BITS-1:0] r_bottom;
    logic                         r_final;

    logic                         ld;
    logic                         take;
    logic signed [PLACE_BITS-1:0] n_min_x;
    logic signed [PLACE_BITS-1:0] n_max_x;
    logic signed [PLACE_BITS-1:0] n_min_y;
    logic signed [PLACE_BITS-1:0] n_max_y;

    assign ld            = !r_valid || o_result.ready;
    assign take          = i_point_valid && ld;
    assign o_point_ready = ld;

    always_comb begin
        n_min_x = (i_point.x < r_min_x) ? i_point.x : r_min_x;
        n_max_x = (i_point.x > r_max_x) ? i_point.x : r_max_x;
        n_min_y = (i_point.y < r_min_y) ? i_point.y : r_min_y;
        n_max_y = (i_point.y > r_max_y) ? i_point.y : r_max_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_min_x <= PLACE_MAX;
            r_max_x <= PLACE_MIN;
            r_min_y <= PLACE_MAX;
            r_max_y <= PLACE_MIN;
        end else begin
            if (ld) begin
                r_valid <= i_point_valid;
            end
            if (take) begin
                // polygon closed: trackers back to the extremes
                r_min_x <= i_point.last ? PLACE_MAX : n_min_x;
                r_max_x <= i_point.last ? PLACE_MIN : n_max_x;
                r_min_y <= i_point.last ? PLACE_MAX : n_min_y;
                r_max_y <= i_point.last ? PLACE_MIN : n_max_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_px     <= i_point.x;
            r_py     <= i_point.y;
            r_left   <= n_min_x;
            r_right  <= n_max_x;
            r_top    <= n_min_y;
            r_bottom <= n_max_y;
            r_final  <= i_point.last;
        end
    end

    assign o_result.valid      = r_valid;
    assign o_result.placed_x   = r_px;
    assign o_result.placed_y   = r_py;
    assign o_result.box_left   = r_left;
    assign o_result.box_right  = r_right;
    assign o_result.box_top    = r_top;
    assign o_result.box_bottom = r_bottom;
    assign o_result.box_final  = r_final;

`ifndef SYNTHESIS
    a_x_in_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_left <= r_px) && (r_px <= r_right))
        else $error("placed x outside box");

    a_y_in_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_top <= r_py) && (r_py <= r_bottom))
        else $error("placed y outside box");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_point.last) |=> (r_min_x == PLACE_MAX) && (r_max_x == PLACE_MIN)
                                   && (r_min_y == PLACE_MAX) && (r_max_y == PLACE_MIN))
        else $error("trackers not cleared after last vertex");

    a_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !i_point.last) |=> (r_min_x == r_left) && (r_max_x == r_right)
                                    && (r_min_y == r_top) && (r_max_y == r_bottom))
        else $error("trackers differ from reported box");
`endif

endmodule

FILE: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rvbb_pkg::*;

    localparam int VB         = 11;
    localparam int TFB        = 14;
    localparam int CYCLE_CAP  = 400000;
    localparam int SHOWN_MAX  = 10;
    localparam int SETTLE_CYC = 8;

    typedef struct packed {
        logic signed [VB-1:0] x;
        logic signed [VB-1:0] y;
        logic                 last;
    } t_vertex;

    typedef struct packed {
        logic signed [PLACE_BITS-1:0] px;
        logic signed [PLACE_BITS-1:0] py;
        logic signed [PLACE_BITS-1:0] left;
        logic signed [PLACE_BITS-1:0] right;
        logic signed [PLACE_BITS-1:0] top;
        logic signed [PLACE_BITS-1:0] bottom;
        logic                         closes;
    } t_box_report;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0] pwdata;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    rvbb_vertex_if #(.VERTEX_BITS(VB)) vin ();
    rvbb_result_if                     vout ();

    rotate_vertices_bounding_box_core #(
        .VERTEX_BITS    (VB),
        .TRIG_FRAC_BITS (TFB)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vertex (vin),
        .o_result (vout),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // geometry copy and box trackers
    logic [CENTER_BITS-1:0] center_x_cfg;
    logic [CENTER_BITS-1:0] center_y_cfg;
    logic [ANGLE_BITS-1:0]  angle_cfg;
    longint                 min_x;
    longint                 max_x;
    longint                 min_y;
    longint                 max_y;
    longint                 sine_lut [0:90];

    t_vertex     vertex_q[$];
    t_box_report box_reports_q[$];

    int unsigned cycles;
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned polygons_closed;
    int unsigned settings_used;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, box_reports_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // sin(d deg) in Q30 by Taylor series, rounded to TFB fraction bits
    function automatic longint quarter_sine(int unsigned d);
        longint unsigned step;
        longint unsigned ang;
        longint unsigned ang2;
        longint unsigned term;
        longint          acc;
        int unsigned     n;
        step = 64'h3243F6A8885A308D / 180;
        ang  = (step * d + (64'd1 << 29)) >> 30;
        ang2 = (ang * ang) >> 30;
        term = ang;
        acc  = signed'(ang);
        for (n = 2; n <= 18; n += 2) begin
            term = ((term * ang2) >> 30) / 64'(n * (n + 1));
            if (((n / 2) % 2) == 1) begin
                acc -= signed'(term);
            end else begin
                acc += signed'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        if (acc > (64'sd1 <<< 30)) begin
            acc = 64'sd1 <<< 30;
        end
        return signed'((unsigned'(acc) + (64'd1 << (30 - TFB - 1))) >> (30 - TFB));
    endfunction

    function automatic longint sine_of(int unsigned a);
        int unsigned m;
        int unsigned r;
        m = a % 360;
        r = m % 90;
        case (m / 90)
            0: return sine_lut[r];
            1: return sine_lut[90 - r];
            2: return -sine_lut[r];
            default: return -sine_lut[90 - r];
        endcase
    endfunction

    function automatic longint clamp_place(longint v);
        if (v > longint'(PLACE_MAX)) begin
            return longint'(PLACE_MAX);
        end
        if (v < longint'(PLACE_MIN)) begin
            return longint'(PLACE_MIN);
        end
        return v;
    endfunction

    function automatic void clear_trackers();
        min_x = longint'(PLACE_MAX);
        max_x = longint'(PLACE_MIN);
        min_y = longint'(PLACE_MAX);
        max_y = longint'(PLACE_MIN);
    endfunction

    function automatic void predict_placement(t_vertex v);
        longint      s;
        longint      c;
        longint      rx;
        longint      ry;
        longint      px;
        longint      py;
        t_box_report r;
        s  = sine_of(int'(angle_cfg));
        c  = sine_of(int'(angle_cfg) + 90);
        // signed division truncates toward zero
        rx = (longint'(v.x) * c - longint'(v.y) * s) / (64'sd1 <<< TFB);
        ry = (longint'(v.x) * s + longint'(v.y) * c) / (64'sd1 <<< TFB);
        px = clamp_place(longint'(center_x_cfg) - rx);
        py = clamp_place(longint'(center_y_cfg) - ry);
        if (px < min_x) min_x = px;
        if (px > max_x) max_x = px;
        if (py < min_y) min_y = py;
        if (py > max_y) max_y = py;
        r.px     = px[PLACE_BITS-1:0];
        r.py     = py[PLACE_BITS-1:0];
        r.left   = min_x[PLACE_BITS-1:0];
        r.right  = max_x[PLACE_BITS-1:0];
        r.top    = min_y[PLACE_BITS-1:0];
        r.bottom = max_y[PLACE_BITS-1:0];
        r.closes = v.last;
        box_reports_q.push_back(r);
        if (v.last) begin
            clear_trackers();
        end
    endfunction

    // vertex driver: bursts with random gaps
    int unsigned burst_left;
    int unsigned gap_left;

    always @(posedge i_clk) begin
        t_vertex v;
        if (!i_rst_n) begin
            vin.valid       <= 1'b0;
            vin.vertex_x    <= '0;
            vin.vertex_y    <= '0;
            vin.last_vertex <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (vin.valid && vin.ready) begin
                predict_placement('{vin.vertex_x, vin.vertex_y, vin.last_vertex});
            end
            if (!vin.valid || vin.ready) begin
                if (gap_left != 0) begin
                    vin.valid <= 1'b0;
                    gap_left--;
                end else if (vertex_q.size() == 0) begin
                    vin.valid <= 1'b0;
                end else begin
                    v = vertex_q.pop_front();
                    vin.valid       <= 1'b1;
                    vin.vertex_x    <= v.x;
                    vin.vertex_y    <= v.y;
                    vin.last_vertex <= v.last;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
    end

    // result monitor with its own stall pattern
    int unsigned stall_mode;
    int unsigned mode_left;
    int unsigned phase_cnt;

    always @(posedge i_clk) begin
        t_box_report got;
        t_box_report want;
        if (!i_rst_n) begin
            vout.ready <= 1'b0;
            stall_mode = 0;
            mode_left  = 0;
            phase_cnt  = 0;
        end else begin
            if (vout.valid && vout.ready) begin
                got = '{vout.placed_x, vout.placed_y, vout.box_left, vout.box_right,
                        vout.box_top, vout.box_bottom, vout.box_final};
                if (box_reports_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= SHOWN_MAX) begin
                        $display("unexpected result px=%0d py=%0d", got.px, got.py);
                    end
                end else begin
                    want = box_reports_q.pop_front();
                    results_seen++;
                    if (want.closes) polygons_closed++;
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= SHOWN_MAX) begin
                            $display("mismatch on result %0d", results_seen);
                            $display("  expected px=%0d py=%0d x=%0d..%0d y=%0d..%0d last=%0b",
                                     want.px, want.py, want.left, want.right,
                                     want.top, want.bottom, want.closes);
                            $display("  actual   px=%0d py=%0d x=%0d..%0d y=%0d..%0d last=%0b",
                                     got.px, got.py, got.left, got.right,
                                     got.top, got.bottom, got.closes);
                        end
                    end
                end
            end
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(16, 96);
            end else begin
                mode_left--;
            end
            phase_cnt++;
            case (stall_mode)
                0: vout.ready <= 1'b1;
                1: vout.ready <= 1'($urandom_range(0, 1));
                2: vout.ready <= (phase_cnt % 7) < 4;
                default: vout.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [DATA_BITS-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BITS'(idx) << REG_LSB;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CENTER_X: center_x_cfg = val[CENTER_BITS-1:0];
            REG_CENTER_Y: center_y_cfg = val[CENTER_BITS-1:0];
            REG_ROTATION: angle_cfg    = val[ANGLE_BITS-1:0];
            default: ;
        endcase
    endtask

    // upper data bits are random; the registers keep only their own width
    task automatic set_geometry(input int unsigned cx, input int unsigned cy,
                                input int unsigned deg);
        write_reg(REG_CENTER_X, ($urandom() & ~32'hFFF) | cx);
        write_reg(REG_CENTER_Y, ($urandom() & ~32'hFFF) | cy);
        write_reg(REG_ROTATION, ($urandom() & ~32'h1FF) | deg);
        settings_used++;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic push_vertex(input int x, input int y, input bit last);
        t_vertex v;
        v.x    = VB'(x);
        v.y    = VB'(y);
        v.last = last;
        vertex_q.push_back(v);
    endtask

    task automatic wait_quiet();
        @(negedge i_clk);
        while (vertex_q.size() != 0 || vin.valid || box_reports_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    function automatic int random_coord();
        case ($urandom_range(0, 7))
            0: return -1024;
            1: return 1023;
            2: return 0;
            default: return int'($urandom_range(0, 2047)) - 1024;
        endcase
    endfunction

    task automatic run_polygons(input int unsigned n);
        int unsigned cnt;
        int unsigned len;
        int unsigned i;
        @(negedge i_clk);
        cnt = 0;
        while (cnt < n) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
            for (i = 0; i < len; i++) begin
                push_vertex(random_coord(), random_coord(), i == len - 1);
            end
            cnt += len;
        end
    endtask

    function automatic int unsigned pick_center();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 4095;
            default: return $urandom_range(0, 4095);
        endcase
    endfunction

    function automatic int unsigned pick_angle();
        case ($urandom_range(0, 7))
            0: return 360;
            1: return 511;
            2: return 90 * $urandom_range(0, 3);
            3: return 45 + 90 * $urandom_range(0, 3);
            default: return $urandom_range(0, 511);
        endcase
    endfunction

    initial begin
        int unsigned d;
        int unsigned p;
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        vin.valid        = 1'b0;
        vin.vertex_x     = '0;
        vin.vertex_y     = '0;
        vin.last_vertex  = 1'b0;
        vout.ready       = 1'b0;
        cycles           = 0;
        mismatches       = 0;
        results_seen     = 0;
        polygons_closed  = 0;
        settings_used    = 0;
        center_x_cfg     = '0;
        center_y_cfg     = '0;
        angle_cfg        = '0;
        clear_trackers();
        for (d = 0; d <= 90; d++) begin
            sine_lut[d] = quarter_sine(d);
        end
        sine_lut[0]  = 0;
        sine_lut[90] = 64'sd1 <<< TFB;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset geometry, first box starts from the reset extremes
        @(negedge i_clk);
        push_vertex(-1024, -1024, 0);
        push_vertex(1023, 1023, 0);
        push_vertex(-1024, 1023, 0);
        push_vertex(1023, -1024, 1);
        push_vertex(0, 0, 1);
        wait_quiet();

        set_geometry(0, 0, 0);
        push_vertex(-1, -1, 0);
        push_vertex(1, 1, 1);
        wait_quiet();

        set_geometry(4095, 4095, 90);
        push_vertex(1023, 0, 0);
        push_vertex(0, 1023, 0);
        push_vertex(-1024, -1024, 1);
        push_vertex(5, -7, 1);
        wait_quiet();

        // 360 wraps to zero
        set_geometry(2048, 1000, 360);
        push_vertex(100, -200, 0);
        push_vertex(-300, 400, 1);
        wait_quiet();

        set_geometry(0, 4095, 511);
        push_vertex(1023, 1023, 0);
        push_vertex(-1024, 0, 1);
        wait_quiet();

        set_geometry(123, 3000, 45);
        push_vertex(1023, -1024, 0);
        push_vertex(-1024, 1023, 0);
        push_vertex(700, 700, 1);
        push_vertex(-1, 0, 1);
        wait_quiet();

        set_geometry(4095, 0, 180);
        push_vertex(1023, 1023, 1);
        push_vertex(-1024, -1024, 1);
        wait_quiet();

        set_geometry(0, 4095, 270);
        push_vertex(-1024, 1023, 0);
        push_vertex(1023, -1024, 1);
        wait_quiet();

        for (p = 0; p < 6; p++) begin
            if (p == 0) begin
                set_geometry(4095, 0, 359);
            end else if (p == 5) begin
                set_geometry(0, 4095, 1);
            end else begin
                set_geometry(pick_center(), pick_center(), pick_angle());
            end
            if (p == 2) begin
                // drain fully mid-phase, then resume
                run_polygons(34);
                wait_quiet();
                run_polygons(34);
            end else begin
                run_polygons(68);
            end
            wait_quiet();
        end

        $display("Checked %0d vertex results, %0d closed polygons, %0d geometry settings.",
                 results_seen, polygons_closed, settings_used);
        $display("Mismatches: %0d, results still outstanding: %0d",
                 mismatches, box_reports_q.size());
        if (mismatches == 0 && box_reports_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
